[hw/rtl/esort_pkg.sv]
// Shared constants and types for the exchange sort block.
`default_nettype none
package esort_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         count_t;

  // Per-cycle command that every cell of the chain sees.
  typedef struct packed {
    logic insert;     // a new word is placed into the sorted chain
    logic shift_out;  // the chain moves one place toward cell zero
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/esort_cell.sv]
// One cell of the sorting chain: holds one word and trades with its neighbors.
`default_nettype none
module esort_cell (
  input  wire logic                clk,
  input  wire esort_pkg::cell_ctrl_t ctrl,
  input  wire esort_pkg::data_t    new_value,
  input  wire logic                occupied,
  input  wire logic                left_goes,
  input  wire esort_pkg::data_t    left_value,
  input  wire esort_pkg::data_t    right_value,
  output logic                     goes,
  output esort_pkg::data_t         value
);
  import esort_pkg::*;

  data_t value_r;
  data_t value_nxt;

  // The new word belongs at or before this cell when the cell is empty or
  // holds a larger word; the chain stays ascending from cell zero.
  assign goes  = !occupied || (new_value < value_r);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.shift_out) begin
      value_nxt = right_value;
    end else if (ctrl.insert && goes) begin
      value_nxt = left_goes ? left_value : new_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/exchange_sort_block.sv]
// Top level of the exchange sort block: a chain of insertion cells plus control.
// Throughput: one word per cycle while a set is being collected; busy stays low.
// After the word marked last is taken, busy is high while the chain shifts all the
// words it holds out through cell zero, one per cycle.
// The first result comes out via the drain flag and the result register; the rest
// follow back to back; the receiver cannot stall them. Reset (rst_n low, synchronous)
// empties the set and clears the drop, drain and out_valid flags.
`default_nettype none
module exchange_sort_block (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire esort_pkg::data_t in_value,
  input  wire logic             in_last_in,
  output logic                  out_valid,
  output esort_pkg::data_t      out_sorted_value,
  output logic                  out_last_out,
  output logic                  out_overflow
);
  import esort_pkg::*;

  // Control state: how many words the chain holds, whether any word of the
  // current set was dropped, and whether the chain is being emptied.
  count_t count_r, count_nxt;
  logic   dropped_r, dropped_nxt;
  logic   drain_r, drain_nxt;

  // Result register, so the chain can keep moving while a result is shown.
  logic   out_valid_r, out_valid_nxt;
  data_t  out_value_r, out_value_nxt;
  logic   out_last_r, out_last_nxt;
  logic   out_ovf_r, out_ovf_nxt;

  logic       accept;
  logic       has_room;
  cell_ctrl_t ctrl;

  logic [CAPACITY-1:0] cell_goes;
  logic [CAPACITY-1:0] cell_occupied;
  data_t               cell_value [CAPACITY];

  assign accept   = start && !drain_r;
  assign has_room = (count_r < count_t'(CAPACITY));
  assign busy     = drain_r;

  // A word is inserted only when there is room; otherwise it is dropped and
  // the drop is remembered for every result of this set.
  assign ctrl.insert    = accept && has_room;
  assign ctrl.shift_out = drain_r;

  // The chain of cells. Each cell sees the broadcast word, its left neighbor
  // (which it takes when the word lands further left) and its right neighbor
  // (which it takes while the chain is being emptied).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  left_goes;
    data_t left_value;
    data_t right_value;

    assign cell_occupied[i] = (count_t'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_goes  = 1'b0;
      assign left_value = in_value;
    end else begin : g_inner
      assign left_goes  = cell_goes[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    esort_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (in_value),
      .occupied    (cell_occupied[i]),
      .left_goes   (left_goes),
      .left_value  (left_value),
      .right_value (right_value),
      .goes        (cell_goes[i]),
      .value       (cell_value[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    drain_nxt     = drain_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = cell_value[0];
    out_last_nxt  = (count_r == count_t'(1));
    out_ovf_nxt   = dropped_r;

    if (drain_r) begin
      // Cell zero always holds the smallest word left; send it and shift.
      out_valid_nxt = 1'b1;
      count_nxt     = count_r - count_t'(1);
      if (count_r == count_t'(1)) begin
        drain_nxt   = 1'b0;
        dropped_nxt = 1'b0;
      end
    end else if (accept) begin
      if (has_room) begin
        count_nxt = count_r + count_t'(1);
      end else begin
        dropped_nxt = 1'b1;
      end
      // The last word always leaves at least one word in the chain.
      if (in_last_in) begin
        drain_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

  // The chain never holds more words than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= count_t'(CAPACITY))
    else $error("word count exceeds chain capacity");

  // Emptying the chain always has a word to send.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (count_r != '0))
    else $error("drain with empty chain");

  // The final word of a set is followed by a gap in the results.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_out) |=> !out_valid)
    else $error("result directly after final word of a set");

  // Every result comes from a cycle in which the chain was being emptied.
  a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(drain_r))
    else $error("result without drain");

endmodule
`default_nettype wire
